@@ sv/gpl_pkg.sv @@
// ----------------------------------------------------------------------------
// gpl_pkg
// shared types, codes and command tables of the game-pad link sequencer
// ----------------------------------------------------------------------------
package gpl_pkg;

  // input kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // operation codes
  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  // configuration register indexes
  localparam logic CFG_SMALL_MOTOR = 1'b0;
  localparam logic CFG_LARGE_MOTOR = 1'b1;

  // reply check values
  localparam logic [7:0] POLL_ACK  = 8'h5a;
  localparam logic [7:0] NO_PAD    = 8'hff;
  localparam logic [7:0] AXIS_FLIP = 8'h80;
  localparam logic [7:0] AXIS_TOP  = 8'h7f;

  localparam int unsigned FRAME_BYTES = 9;
  localparam logic [3:0]  POLL_LEN    = 4'd9;
  localparam logic [3:0]  CHECK_POS   = 4'd2;
  localparam logic [3:0]  PAD_FIRST   = 4'd3;
  localparam logic [3:0]  SMALL_POS   = 4'd3;
  localparam logic [3:0]  LARGE_POS   = 4'd4;
  localparam logic [1:0]  LAST_FRAME  = 2'd3;
  localparam int unsigned PAD_COUNT   = 6;

  // enter config, analog mode, vibration enable, exit config
  localparam logic [7:0] SETUP_FRAMES [4][FRAME_BYTES] = '{
    '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h4d, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff},
    '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5a, 8'h5a, 8'h5a, 8'h5a, 8'h5a}
  };
  localparam logic [3:0] SETUP_LEN [4] = '{4'd5, 4'd9, 4'd9, 4'd9};
  localparam logic [7:0] POLL_FRAME [FRAME_BYTES] = '{
    8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // pad byte store update from the sequencer
  typedef struct packed {
    logic       we;
    logic [2:0] idx;
    logic [7:0] data;
    logic       link_set;
    logic       link_clr;
  } pad_wr_t;

  // decoded pad status
  typedef struct packed {
    logic              connected;
    logic [15:0]       buttons;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
  } pad_status_t;

  // command byte for a given operation, frame and byte position
  function automatic logic [7:0] cmd_byte(input logic [1:0] op, input logic [1:0] frame,
                                          input logic [3:0] pos, input logic small_on,
                                          input logic [7:0] large_lvl);
    logic [7:0] b;
    b = 8'h00;
    if (pos < POLL_LEN) begin
      if (op == OP_POLL) begin
        if (pos == SMALL_POS)      b = {7'd0, small_on};
        else if (pos == LARGE_POS) b = large_lvl;
        else                       b = POLL_FRAME[pos];
      end else begin
        b = SETUP_FRAMES[frame][pos];
      end
    end
    return b;
  endfunction

endpackage

@@ sv/gpl_cmd_if.sv @@
// ----------------------------------------------------------------------------
// gpl_cmd_if
// request channel: start commands and reply bytes
// ----------------------------------------------------------------------------
interface gpl_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

@@ sv/gpl_res_if.sv @@
// ----------------------------------------------------------------------------
// gpl_res_if
// result channel: next transmit byte, frame marks and decoded pad state
// ----------------------------------------------------------------------------
interface gpl_res_if;
  logic              valid;
  logic              ready;
  logic [7:0]        tx_byte;
  logic              tx_valid;
  logic              frame_start;
  logic              frame_end;
  logic              done_res;
  logic              failed;
  logic              connected;
  logic [15:0]       buttons;
  logic signed [7:0] right_x;
  logic signed [7:0] right_y;
  logic signed [7:0] left_x;
  logic signed [7:0] left_y;

  modport source (output valid, tx_byte, tx_valid, frame_start, frame_end, done_res, failed,
                  connected, buttons, right_x, right_y, left_x, left_y, input ready);
  modport sink   (input valid, tx_byte, tx_valid, frame_start, frame_end, done_res, failed,
                  connected, buttons, right_x, right_y, left_x, left_y, output ready);
endinterface

@@ sv/gpl_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gpl_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface gpl_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/gpl_seq.sv @@
// ----------------------------------------------------------------------------
// gpl_seq
// link sequencer: operation state, frame and byte counters, next command byte
// ----------------------------------------------------------------------------
module gpl_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [1:0]       kind,
  input  logic [7:0]       rx_byte,
  input  logic             small_motor_on,
  input  logic [7:0]       large_motor_level,
  output logic [7:0]       tx_byte,
  output logic             tx_valid,
  output logic             frame_start,
  output logic             frame_end,
  output logic             done_res,
  output logic             failed,
  output gpl_pkg::pad_wr_t pad_wr
);
  import gpl_pkg::*;

  logic [1:0] operation;
  logic [1:0] operation_next;
  logic [1:0] frame_number;
  logic [1:0] frame_number_next;
  logic [3:0] byte_position;
  logic [3:0] byte_position_next;
  logic       reply_ok;
  logic       reply_ok_next;
  logic       is_poll;
  logic [3:0] frame_len;
  logic [3:0] pos_inc;
  logic [3:0] pad_off;

  assign is_poll   = (operation == OP_POLL);
  assign frame_len = is_poll ? POLL_LEN : SETUP_LEN[frame_number];
  assign pos_inc   = byte_position + 4'd1;
  assign pad_off   = byte_position - PAD_FIRST;

  always_comb begin
    operation_next     = operation;
    frame_number_next  = frame_number;
    byte_position_next = byte_position;
    reply_ok_next      = reply_ok;
    tx_byte            = 8'h00;
    tx_valid           = 1'b0;
    frame_start        = 1'b0;
    frame_end          = 1'b0;
    done_res           = 1'b0;
    failed             = 1'b0;
    pad_wr             = '0;
    unique case (kind)
      KIND_INIT, KIND_POLL: begin
        operation_next     = (kind == KIND_INIT) ? OP_INIT : OP_POLL;
        frame_number_next  = 2'd0;
        byte_position_next = 4'd0;
        reply_ok_next      = 1'b0;
        pad_wr.link_clr    = (kind == KIND_INIT);
        tx_byte            = cmd_byte(operation_next, 2'd0, 4'd0, small_motor_on,
                                      large_motor_level);
        tx_valid           = 1'b1;
        frame_start        = 1'b1;
      end
      KIND_REPLY: begin
        if (operation != OP_IDLE) begin
          if (byte_position == CHECK_POS) begin
            if (is_poll) reply_ok_next = (rx_byte == POLL_ACK);
            else         reply_ok_next = (frame_number != 2'd0) || (rx_byte != NO_PAD);
          end
          // capture pad bytes once the poll ack has been seen
          if (is_poll && reply_ok_next && byte_position >= PAD_FIRST &&
              byte_position < POLL_LEN) begin
            pad_wr.we   = 1'b1;
            pad_wr.idx  = pad_off[2:0];
            pad_wr.data = rx_byte;
          end
          byte_position_next = pos_inc;
          if (pos_inc < frame_len) begin
            tx_byte  = cmd_byte(operation, frame_number, pos_inc, small_motor_on,
                                large_motor_level);
            tx_valid = 1'b1;
          end else begin
            frame_end = 1'b1;
            if (is_poll) begin
              done_res        = 1'b1;
              failed          = !reply_ok_next;
              pad_wr.link_set = reply_ok_next;
              operation_next  = OP_IDLE;
            end else if (frame_number == 2'd0 && !reply_ok_next) begin
              done_res       = 1'b1;
              failed         = 1'b1;
              operation_next = OP_IDLE;
            end else if (frame_number == LAST_FRAME) begin
              done_res       = 1'b1;
              operation_next = OP_IDLE;
            end else begin
              frame_number_next  = frame_number + 2'd1;
              byte_position_next = 4'd0;
              tx_byte            = cmd_byte(operation, frame_number_next, 4'd0,
                                            small_motor_on, large_motor_level);
              tx_valid           = 1'b1;
              frame_start        = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation     <= OP_IDLE;
      frame_number  <= 2'd0;
      byte_position <= 4'd0;
      reply_ok      <= 1'b0;
    end else if (fire) begin
      operation     <= operation_next;
      frame_number  <= frame_number_next;
      byte_position <= byte_position_next;
      reply_ok      <= reply_ok_next;
    end
  end

endmodule

@@ sv/gpl_pad.sv @@
// ----------------------------------------------------------------------------
// gpl_pad
// pad byte store, link flag and button / stick decode
// ----------------------------------------------------------------------------
module gpl_pad (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  gpl_pkg::pad_wr_t     pad_wr,
  output gpl_pkg::pad_status_t status
);
  import gpl_pkg::*;

  logic [7:0] pad_bytes      [PAD_COUNT];
  logic [7:0] pad_bytes_next [PAD_COUNT];
  logic       link_up;
  logic       link_up_next;

  always_comb begin
    for (int i = 0; i < PAD_COUNT; i++) begin
      pad_bytes_next[i] = pad_bytes[i];
    end
    if (pad_wr.we) pad_bytes_next[pad_wr.idx] = pad_wr.data;
    link_up_next = link_up;
    if (pad_wr.link_clr)      link_up_next = 1'b0;
    else if (pad_wr.link_set) link_up_next = 1'b1;
  end

  // decode from the updated state so the result matches this request
  always_comb begin
    status = '0;
    if (link_up_next) begin
      status.connected = 1'b1;
      status.buttons   = ~{pad_bytes_next[1], pad_bytes_next[0]};
      status.right_x   = pad_bytes_next[2] ^ AXIS_FLIP;
      status.right_y   = AXIS_TOP - pad_bytes_next[3];
      status.left_x    = pad_bytes_next[4] ^ AXIS_FLIP;
      status.left_y    = AXIS_TOP - pad_bytes_next[5];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        pad_bytes[i] <= pad_bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up <= 1'b0;
    end else if (fire) begin
      link_up <= link_up_next;
    end
  end

endmodule

@@ sv/game_pad_link_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// game_pad_link_sequencer_core
// sequences game-pad link command frames and decodes the pad replies
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                     | handshake
//  --------+-----+---------------------------------------------+------------
//  cmd     | in  | kind, rx_byte                               | valid/ready
//  res     | out | tx_byte, marks, status, buttons, four axes  | valid/ready
//  cfg     | in  | index, data (motor settings)                | valid/ready
//
//  one request enters every cycle while the input is open; each request
//  passes through the input register, then the result register
//  the sequencer state advances when a request moves from the input
//  register into the result register
//  a held result stalls only the input register; the input stays open
//  while the input register is empty or moving on
//  rst is synchronous: operation idle, counters cleared, link down,
//  motor settings zero; pad bytes are not cleared
// ----------------------------------------------------------------------------
module game_pad_link_sequencer_core (
  input logic  clk,
  input logic  rst,
  gpl_cmd_if.sink   cmd,
  gpl_res_if.source res,
  gpl_cfg_if.sink   cfg
);
  import gpl_pkg::*;

  // motor settings
  logic       small_motor_on;
  logic [7:0] large_motor_level;

  // input register
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_rx;
  logic       s1_adv;
  logic       fire;

  // combinational results of the request in the input register
  logic        seq_tx_valid;
  logic [7:0]  seq_tx_byte;
  logic        seq_frame_start;
  logic        seq_frame_end;
  logic        seq_done;
  logic        seq_failed;
  pad_wr_t     pad_wr;
  pad_status_t status;

  // config writes always land
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_motor_on    <= 1'b0;
      large_motor_level <= 8'h00;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SMALL_MOTOR: small_motor_on    <= cfg.data[0];
        CFG_LARGE_MOTOR: large_motor_level <= cfg.data;
      endcase
    end
  end

  // result register free or draining this cycle
  assign s1_adv    = !res.valid || res.ready;
  assign fire      = s1_valid && s1_adv;
  assign cmd.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind <= cmd.kind;
      s1_rx   <= cmd.rx_byte;
    end
  end

  gpl_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .kind              (s1_kind),
    .rx_byte           (s1_rx),
    .small_motor_on    (small_motor_on),
    .large_motor_level (large_motor_level),
    .tx_byte           (seq_tx_byte),
    .tx_valid          (seq_tx_valid),
    .frame_start       (seq_frame_start),
    .frame_end         (seq_frame_end),
    .done_res          (seq_done),
    .failed            (seq_failed),
    .pad_wr            (pad_wr)
  );

  gpl_pad u_pad (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .pad_wr (pad_wr),
    .status (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.tx_byte     <= seq_tx_byte;
      res.tx_valid    <= seq_tx_valid;
      res.frame_start <= seq_frame_start;
      res.frame_end   <= seq_frame_end;
      res.done_res    <= seq_done;
      res.failed      <= seq_failed;
      res.connected   <= status.connected;
      res.buttons     <= status.buttons;
      res.right_x     <= status.right_x;
      res.right_y     <= status.right_y;
      res.left_x      <= status.left_x;
      res.left_y      <= status.left_y;
    end
  end

endmodule
